// ===== rtl/core/mke_pkg.sv =====
package mke_pkg;

  localparam int NUM_CLASSES = 12;
  localparam int NB          = 20;  // scaled bins lie below 2^NB
  localparam int DW          = 25;  // centered bin, signed
  localparam int PW          = 14;  // centered profile tap, signed
  localparam int DOTW        = 44;
  localparam int NDW         = 54;
  localparam int RW          = 27;
  localparam int DENW        = RW + PW;
  localparam int NUMW        = DOTW + 15;
  localparam int SCW         = 18;

  typedef logic [2:0] cell_op_t;

  localparam cell_op_t OP_HOLD  = 3'd0;
  localparam cell_op_t OP_DECAY = 3'd1;
  localparam cell_op_t OP_ADD   = 3'd2;
  localparam cell_op_t OP_LOAD  = 3'd3;
  localparam cell_op_t OP_SHR   = 3'd4;
  localparam cell_op_t OP_SHL   = 3'd5;
  localparam cell_op_t OP_ROT   = 3'd6;
  localparam cell_op_t OP_CTR   = 3'd7;

  typedef struct packed {
    cell_op_t              op;
    logic [15:0]           decay;
    logic [16:0]           weight;
    logic [3:0]            pc;
    logic signed [DW-1:0]  sum;
  } mke_cell_ctl_t;

  // probe-tone profiles x100, centered as 12*p - sum(p)
  localparam logic signed [PW-1:0] PROF_MAJ [NUM_CLASSES] = '{
    14'sd3441, -14'sd1503, -14'sd3,    -14'sd1383, 14'sd1077, 14'sd729,
    -14'sd1155, 14'sd2049, -14'sd1311, 14'sd213,   -14'sd1431, -14'sd723
  };
  localparam logic signed [PW-1:0] PROF_MIN [NUM_CLASSES] = '{
    14'sd3145, -14'sd1235, -14'sd227,  14'sd2005,  -14'sd1331, -14'sd215,
    -14'sd1403, 14'sd1249, 14'sd325,   -14'sd1223, -14'sd443,  -14'sd647
  };

  function automatic logic signed [PW-1:0] prof_tap(input logic minor,
                                                    input logic [3:0] idx);
    return minor ? PROF_MIN[idx] : PROF_MAJ[idx];
  endfunction

  function automatic int prof_sq_sum(input logic minor);
    int s;
    int p;
    s = 0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      p = minor ? int'(PROF_MIN[i]) : int'(PROF_MAJ[i]);
      s = s + p * p;
    end
    return s;
  endfunction

  function automatic int isqrt_c(input int val);
    int v;
    int r;
    int b;
    v = val;
    r = 0;
    b = 1 << 30;
    for (int i = 0; i < 16; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  localparam logic [PW-1:0] PN_MAJ = PW'(isqrt_c(prof_sq_sum(1'b0)));
  localparam logic [PW-1:0] PN_MIN = PW'(isqrt_c(prof_sq_sum(1'b1)));

  function automatic logic [3:0] mod12(input logic [7:0] x);
    logic [7:0] t;
    t = x;
    if (t >= 8'd96) t = t - 8'd96;
    if (t >= 8'd48) t = t - 8'd48;
    if (t >= 8'd24) t = t - 8'd24;
    if (t >= 8'd12) t = t - 8'd12;
    return t[3:0];
  endfunction

endpackage

// ===== rtl/core/mke_in_if.sv =====
interface mke_in_if;
  logic        valid;
  logic        ready;
  logic [14:0] note_pitch;
  logic        voiced;
  logic [16:0] note_weight;

  modport source (output valid, note_pitch, voiced, note_weight, input ready);
  modport sink (input valid, note_pitch, voiced, note_weight, output ready);
endinterface

// ===== rtl/core/mke_out_if.sv =====
interface mke_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  root_class;
  logic        is_minor;
  logic [15:0] confidence;
  logic        estimate_valid;

  modport source (output valid, root_class, is_minor, confidence, estimate_valid,
                  input ready);
  modport sink (input valid, root_class, is_minor, confidence, estimate_valid,
                output ready);
endinterface

// ===== rtl/core/mke_cell.sv =====
module mke_cell
  import mke_pkg::*;
#(
  parameter int         BW  = 32,
  parameter int         SW  = 32,
  parameter logic [3:0] IDX = 4'd0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mke_cell_ctl_t ctl,
  input  logic [SW-1:0] nbr,
  output logic [SW-1:0] scr
);

  logic [BW-1:0]        bin_r, bin_nxt;
  logic [SW-1:0]        scr_r, scr_nxt;
  logic [BW+15:0]       prod;
  logic [BW:0]          add_s;
  logic [23:0]          tw;
  logic signed [DW-1:0] d;

  assign prod  = {16'd0, bin_r} * {{BW{1'b0}}, ctl.decay};
  assign add_s = {1'b0, bin_r} + (BW+1)'(ctl.weight);
  assign tw    = {4'd0, scr_r[NB-1:0]} * 24'd12;
  assign d     = $signed({1'b0, tw}) - ctl.sum;
  assign scr   = scr_r;

  always_comb begin
    bin_nxt = bin_r;
    scr_nxt = scr_r;
    unique case (ctl.op)
      OP_HOLD:  ;
      OP_DECAY: bin_nxt = prod[BW+15:16];
      OP_ADD: begin
        if (ctl.pc == IDX) begin
          bin_nxt = add_s[BW] ? {BW{1'b1}} : add_s[BW-1:0];
        end
      end
      OP_LOAD:  scr_nxt = SW'(bin_r);
      OP_SHR:   scr_nxt = scr_r >> 1;
      OP_SHL:   scr_nxt = scr_r << 1;
      OP_ROT:   scr_nxt = nbr;
      OP_CTR:   scr_nxt = SW'(d);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_r <= '0;
    end else begin
      bin_r <= bin_nxt;
    end
    scr_r <= scr_nxt;
  end

endmodule

// ===== rtl/core/musical_key_estimator.sv =====
// Key estimator over a ring of twelve pitch-class cells. On each accepted hop
// the cells decay their bins, then the hit cell adds the weight. On a
// recompute hop the bins rotate past one shared unit that finds the maximum,
// scales, centers, sums squares, takes a 27-step square root and then scores
// the 24 keys one after another (12 multiply-accumulates, a 16-step divide)
// on that single multiply-accumulate and divider. A result waits in an output
// register while the next hop is taken. Registers at byte address 4*i:
// decay_factor, recompute_interval, min_total_weight, valid_score_threshold.
module musical_key_estimator
  import mke_pkg::*;
#(
  parameter int BIN_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  mke_in_if.sink           in_ch,
  mke_out_if.source        out_ch,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int BW = BIN_WIDTH;
  localparam int SW = (BW > DW) ? BW : DW + 1;
  localparam int CW = (BW > 28) ? BW : 28;

  localparam logic [1:0] REG_DECAY = 2'd0;
  localparam logic [1:0] REG_INTV  = 2'd1;
  localparam logic [1:0] REG_MINW  = 2'd2;
  localparam logic [1:0] REG_THR   = 2'd3;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_ADD   = 5'd1;
  localparam logic [4:0] S_CHK   = 5'd2;
  localparam logic [4:0] S_MAX   = 5'd3;
  localparam logic [4:0] S_NORM  = 5'd4;
  localparam logic [4:0] S_SUM   = 5'd5;
  localparam logic [4:0] S_CTR   = 5'd6;
  localparam logic [4:0] S_ND    = 5'd7;
  localparam logic [4:0] S_NDCHK = 5'd8;
  localparam logic [4:0] S_SQRT  = 5'd9;
  localparam logic [4:0] S_DOT   = 5'd10;
  localparam logic [4:0] S_DEN   = 5'd11;
  localparam logic [4:0] S_DCHK  = 5'd12;
  localparam logic [4:0] S_DIV   = 5'd13;
  localparam logic [4:0] S_UPD   = 5'd14;
  localparam logic [4:0] S_FIN   = 5'd15;
  localparam logic [4:0] S_CONF  = 5'd16;
  localparam logic [4:0] S_EMIT  = 5'd17;

  localparam logic [3:0] LAST_TAP = 4'(NUM_CLASSES - 1);
  localparam logic [4:0] LAST_KEY = 5'(2 * NUM_CLASSES - 1);

  logic [4:0]  state_r;
  logic [15:0] decay_r, intv_r;
  logic [11:0] minw_r;
  logic [14:0] thr_r;
  logic [15:0] hop_cnt_r;
  logic [BW-1:0] wt_r;
  logic [3:0]  pc_r;
  logic [16:0] w_r;
  logic        hit_r;
  logic [3:0]  cnt_r;
  logic [4:0]  step_r;
  logic [4:0]  key_r;
  logic [BW-1:0] mx_r;
  logic [DW-1:0] sum_r;
  logic [NDW-1:0] nd_r, sq_v_r, sq_q_r, sq_bit_r;
  logic [RW-1:0] dn_r;
  logic signed [DOTW-1:0] dot_r;
  logic [DENW-1:0] den_r;
  logic [NUMW-1:0] rem_r;
  logic [15:0] q_r;
  logic        neg_r;
  logic signed [SCW-1:0] best_r, second_r;
  logic [4:0]  best_key_r;
  logic [15:0] margin_r, bclamp_r;
  logic [3:0]  held_root_r;
  logic        held_minor_r;
  logic [15:0] held_conf_r;
  logic        vflag_r;
  logic        out_valid_r;
  logic [3:0]  out_root_r;
  logic        out_minor_r;
  logic [15:0] out_conf_r;
  logic        out_ev_r;

  mke_cell_ctl_t ctl;
  logic [SW-1:0] scr_w [NUM_CLASSES];
  logic signed [DW-1:0] hd;
  logic [BW-1:0] head_bin, mx_new;
  logic        in_acc, cfg_wr, out_load;
  logic [15:0] pitch_r16;
  logic [BW+15:0] wt_prod;
  logic [BW:0] wt_add;
  logic [3:0]  root, tap;
  logic signed [PW-1:0] ptap;
  logic signed [DW+PW-1:0] mac;
  logic signed [2*DW-1:0] sqp;
  logic [NDW-1:0] sq_t;
  logic [DOTW-1:0] dmag;
  logic [NUMW-1:0] lim, trial;
  logic signed [SCW-1:0] qs, sc;
  logic signed [SCW:0] diff;
  logic signed [SCW+2:0] m4;
  logic [31:0] conf_p;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign cfg_wr    = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_load  = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid          = out_valid_r;
  assign out_ch.root_class     = out_root_r;
  assign out_ch.is_minor       = out_minor_r;
  assign out_ch.confidence     = out_conf_r;
  assign out_ch.estimate_valid = out_ev_r;

  always_comb begin
    unique case (paddr[3:2])
      REG_DECAY: prdata = {16'd0, decay_r};
      REG_INTV:  prdata = {16'd0, intv_r};
      REG_MINW:  prdata = {20'd0, minw_r};
      REG_THR:   prdata = {17'd0, thr_r};
    endcase
  end

  genvar k;
  generate
    for (k = 0; k < NUM_CLASSES; k++) begin : g_cell
      mke_cell #(.BW(BW), .SW(SW), .IDX(4'(k))) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .nbr   (scr_w[(k + 1) % NUM_CLASSES]),
        .scr   (scr_w[k])
      );
    end
  endgenerate

  assign hd       = $signed(scr_w[0][DW-1:0]);
  assign head_bin = scr_w[0][BW-1:0];
  assign mx_new   = (head_bin > mx_r) ? head_bin : mx_r;
  assign pitch_r16 = {1'b0, in_ch.note_pitch} + 16'd128;
  assign wt_prod  = {16'd0, wt_r} * {{BW{1'b0}}, decay_r};
  assign wt_add   = {1'b0, wt_r} + (BW+1)'(w_r);

  assign root = key_r[4:1];
  assign tap  = (cnt_r >= root) ? cnt_r - root : cnt_r + 4'(NUM_CLASSES) - root;
  assign ptap = prof_tap(key_r[0], tap);
  assign mac  = hd * ptap;
  assign sqp  = hd * hd;
  assign sq_t = sq_q_r + sq_bit_r;
  assign dmag = dot_r[DOTW-1] ? DOTW'(-dot_r) : DOTW'(dot_r);
  assign lim  = NUMW'({den_r, 15'd0}) + NUMW'(den_r);
  assign trial = NUMW'(den_r) << step_r[3:0];
  assign qs   = $signed({2'b00, q_r});
  assign sc   = neg_r ? -qs : qs;
  assign diff = {best_r[SCW-1], best_r} - {second_r[SCW-1], second_r};
  assign m4   = {diff, 2'b00};
  assign conf_p = {16'd0, margin_r} * {16'd0, bclamp_r};

  always_comb begin
    ctl.decay  = decay_r;
    ctl.weight = w_r;
    ctl.pc     = pc_r;
    ctl.sum    = $signed(sum_r);
    ctl.op     = OP_HOLD;
    unique case (state_r)
      S_IDLE: ctl.op = in_acc ? OP_DECAY : OP_HOLD;
      S_ADD:  ctl.op = hit_r ? OP_ADD : OP_HOLD;
      S_CHK:  ctl.op = OP_LOAD;
      S_MAX, S_SUM, S_ND, S_DOT: ctl.op = OP_ROT;
      S_NORM: begin
        priority if (mx_r[BW-1:NB] != '0) ctl.op = OP_SHR;
        else if (mx_r[BW-1:NB-1] == '0)  ctl.op = OP_SHL;
        else                             ctl.op = OP_HOLD;
      end
      S_CTR:  ctl.op = OP_CTR;
      default: ctl.op = OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      decay_r      <= 16'd65520;
      intv_r       <= 16'd40;
      minw_r       <= 12'd20;
      thr_r        <= 15'd6554;
      hop_cnt_r    <= '0;
      wt_r         <= '0;
      held_root_r  <= '0;
      held_minor_r <= 1'b0;
      held_conf_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_DECAY: decay_r <= pwdata[15:0];
          REG_INTV:  intv_r  <= pwdata[15:0];
          REG_MINW:  minw_r  <= pwdata[11:0];
          REG_THR:   thr_r   <= pwdata[14:0];
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            wt_r    <= wt_prod[BW+15:16];
            pc_r    <= mod12(pitch_r16[15:8]);
            w_r     <= in_ch.note_weight[16] ? 17'h10000 : in_ch.note_weight;
            hit_r   <= in_ch.voiced && (in_ch.note_pitch != '0);
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          if (hit_r) wt_r <= wt_add[BW] ? {BW{1'b1}} : wt_add[BW-1:0];
          if (hop_cnt_r > 16'd1) begin
            hop_cnt_r <= hop_cnt_r - 16'd1;
            state_r   <= S_IDLE;
          end else begin
            hop_cnt_r <= intv_r;
            state_r   <= S_CHK;
          end
        end
        S_CHK: begin
          mx_r  <= '0;
          cnt_r <= '0;
          if (CW'(wt_r) < CW'({minw_r, 16'd0})) begin
            vflag_r <= 1'b0;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_MAX;
          end
        end
        S_MAX: begin
          mx_r  <= mx_new;
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == LAST_TAP) begin
            cnt_r <= '0;
            if (mx_new == '0) begin
              vflag_r <= 1'b0;
              state_r <= S_EMIT;
            end else begin
              state_r <= S_NORM;
            end
          end
        end
        S_NORM: begin
          priority if (mx_r[BW-1:NB] != '0) begin
            mx_r <= mx_r >> 1;
          end else if (mx_r[BW-1:NB-1] == '0) begin
            mx_r <= mx_r << 1;
          end else begin
            sum_r   <= '0;
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          sum_r <= sum_r + DW'(head_bin[NB-1:0]);
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == LAST_TAP) begin
            cnt_r   <= '0;
            state_r <= S_CTR;
          end
        end
        S_CTR: begin
          nd_r    <= '0;
          state_r <= S_ND;
        end
        S_ND: begin
          nd_r  <= nd_r + NDW'(sqp);
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == LAST_TAP) begin
            cnt_r   <= '0;
            state_r <= S_NDCHK;
          end
        end
        S_NDCHK: begin
          if (nd_r == '0) begin
            vflag_r <= 1'b0;
            state_r <= S_EMIT;
          end else begin
            sq_v_r   <= nd_r;
            sq_q_r   <= '0;
            sq_bit_r <= NDW'(1) << (NDW - 2);
            step_r   <= '0;
            state_r  <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_v_r >= sq_t) begin
            sq_v_r <= sq_v_r - sq_t;
            sq_q_r <= (sq_q_r >> 1) + sq_bit_r;
          end else begin
            sq_q_r <= sq_q_r >> 1;
          end
          sq_bit_r <= sq_bit_r >> 2;
          step_r   <= step_r + 5'd1;
          if (step_r == 5'(NDW / 2 - 1)) begin
            key_r    <= '0;
            cnt_r    <= '0;
            dot_r    <= '0;
            best_r   <= -SCW'(65536);
            second_r <= -SCW'(65536);
            state_r  <= S_DOT;
          end
        end
        S_DOT: begin
          if (step_r != '0) dn_r <= sq_q_r[RW-1:0];
          step_r <= '0;
          dot_r  <= dot_r + DOTW'(mac);
          cnt_r  <= cnt_r + 4'd1;
          if (cnt_r == LAST_TAP) begin
            cnt_r   <= '0;
            state_r <= S_DEN;
          end
        end
        S_DEN: begin
          den_r   <= {{PW{1'b0}}, dn_r} * {{RW{1'b0}}, (key_r[0] ? PN_MIN : PN_MAJ)};
          rem_r   <= {dmag, 15'd0};
          neg_r   <= dot_r[DOTW-1];
          state_r <= S_DCHK;
        end
        S_DCHK: begin
          priority if (den_r == '0) begin
            q_r     <= '0;
            state_r <= S_UPD;
          end else if (rem_r >= lim) begin
            q_r     <= 16'h8000;
            state_r <= S_UPD;
          end else begin
            q_r     <= '0;
            step_r  <= 5'd15;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_r >= trial) begin
            rem_r              <= rem_r - trial;
            q_r[step_r[3:0]]   <= 1'b1;
          end
          step_r <= step_r - 5'd1;
          if (step_r == '0) state_r <= S_UPD;
        end
        S_UPD: begin
          priority if (sc > best_r) begin
            second_r   <= best_r;
            best_r     <= sc;
            best_key_r <= key_r;
          end else if (sc > second_r) begin
            second_r <= sc;
          end
          step_r <= '0;
          dot_r  <= '0;
          cnt_r  <= '0;
          if (key_r == LAST_KEY) begin
            state_r <= S_FIN;
          end else begin
            key_r   <= key_r + 5'd1;
            state_r <= S_DOT;
          end
        end
        S_FIN: begin
          priority if (m4 <= 0) margin_r <= '0;
          else if (m4 > (SCW+3)'(32768)) margin_r <= 16'h8000;
          else margin_r <= m4[15:0];
          priority if (best_r < 0) bclamp_r <= '0;
          else if (best_r > SCW'(32768)) bclamp_r <= 16'h8000;
          else bclamp_r <= best_r[15:0];
          state_r <= S_CONF;
        end
        S_CONF: begin
          held_conf_r  <= conf_p[30:15];
          held_root_r  <= best_key_r[4:1];
          held_minor_r <= best_key_r[0];
          vflag_r      <= best_r > $signed({3'b000, thr_r});
          state_r      <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_root_r  <= held_root_r;
      out_minor_r <= held_minor_r;
      out_conf_r  <= held_conf_r;
      out_ev_r    <= vflag_r;
    end
  end

endmodule
